@@ hdl/urf_pkg.sv @@
// ----------------------------------------------------------------------------
// urf_pkg: shared types and constants of the UART receiver with FIFO
// Register indexes, field widths, reset values and the structs passed
// between the receiver, the FIFO and the top level.
// ----------------------------------------------------------------------------
package urf_pkg;

  localparam int FIFO_DEPTH_DEF = 64;

  localparam int BIT_PERIOD_W = 17;
  localparam int DELAY_W      = 18;
  localparam int CFG_DATA_W   = 18;
  localparam int CFG_IDX_W    = 2;
  localparam int FILL_W       = 6;
  localparam int SLOT_W       = 4;

  localparam logic [BIT_PERIOD_W-1:0] BIT_PERIOD_RST = 17'd694;
  localparam logic [DELAY_W-1:0]      DELAY_RST      = 18'd425;

  // Number of data bits per frame and the largest fill count reported.
  localparam logic [SLOT_W-1:0] DATA_BITS = 4'd8;
  localparam logic [FILL_W-1:0] FILL_MAX  = 6'd63;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIT_PERIOD  = 2'd0,
    REG_FIRST_DELAY = 2'd1,
    REG_PARITY      = 2'd2,
    REG_INVERT      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [BIT_PERIOD_W-1:0] bit_period;
    logic [DELAY_W-1:0]      first_delay;
    logic                    parity_en;
    logic                    invert;
  } cfg_t;

  // Frame completion from the receiver toward the FIFO.
  typedef struct packed {
    logic       done;
    logic [7:0] data;
  } rx_evt_t;

  // FIFO status at the start of a tick.
  typedef struct packed {
    logic              head_valid;
    logic [7:0]        head_byte;
    logic [FILL_W-1:0] fill;
    logic              overflow;
  } fifo_stat_t;

endpackage

@@ hdl/urf_rx.sv @@
// ----------------------------------------------------------------------------
// urf_rx: serial frame receiver
// Detects the start edge, times the bit samples and assembles one byte.
// ----------------------------------------------------------------------------
module urf_rx (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            tick,
  input  logic            line,
  input  urf_pkg::cfg_t   cfg,
  output urf_pkg::rx_evt_t evt
);

  logic                         busy_r, busy_nxt;
  logic [urf_pkg::DELAY_W-1:0]  tc_r, tc_nxt;
  logic [urf_pkg::SLOT_W-1:0]   slot_r, slot_nxt;
  logic [7:0]                   shift_r, shift_nxt;
  logic                         last_r;

  logic [urf_pkg::DELAY_W-1:0]  tc_dec;
  logic [urf_pkg::DELAY_W-1:0]  bit_ticks;
  logic [urf_pkg::DELAY_W-1:0]  first_ticks;
  logic [urf_pkg::SLOT_W-1:0]   stop_slot;
  logic                         start_edge;
  logic                         done;

  // A zero timing register behaves as one tick.
  assign bit_ticks   = (cfg.bit_period == '0) ? urf_pkg::DELAY_W'(1)
                                              : urf_pkg::DELAY_W'(cfg.bit_period);
  assign first_ticks = (cfg.first_delay == '0) ? urf_pkg::DELAY_W'(1) : cfg.first_delay;
  assign stop_slot   = cfg.parity_en ? urf_pkg::DATA_BITS + 4'd1 : urf_pkg::DATA_BITS;
  assign tc_dec      = tc_r - urf_pkg::DELAY_W'(1);
  assign start_edge  = cfg.invert ? (!last_r && line) : (last_r && !line);

  always_comb begin
    busy_nxt  = busy_r;
    tc_nxt    = tc_r;
    slot_nxt  = slot_r;
    shift_nxt = shift_r;
    done      = 1'b0;
    if (!busy_r) begin
      if (start_edge) begin
        busy_nxt  = 1'b1;
        slot_nxt  = '0;
        shift_nxt = '0;
        tc_nxt    = first_ticks;
      end
    end else begin
      tc_nxt = tc_dec;
      if (tc_dec == '0) begin
        if (slot_r < urf_pkg::DATA_BITS) begin
          shift_nxt = {line, shift_r[7:1]};
          slot_nxt  = slot_r + 4'd1;
          tc_nxt    = bit_ticks;
        end else if (slot_r < stop_slot) begin
          slot_nxt = slot_r + 4'd1;
          tc_nxt   = bit_ticks;
        end else begin
          busy_nxt = 1'b0;
          slot_nxt = '0;
          done     = 1'b1;
        end
      end
    end
  end

  assign evt.done = done;
  assign evt.data = cfg.invert ? ~shift_r : shift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      tc_r    <= '0;
      slot_r  <= '0;
      shift_r <= '0;
      last_r  <= 1'b1;
    end else if (tick) begin
      busy_r  <= busy_nxt;
      tc_r    <= tc_nxt;
      slot_r  <= slot_nxt;
      shift_r <= shift_nxt;
      last_r  <= line;
    end
  end

endmodule

@@ hdl/urf_fifo.sv @@
// ----------------------------------------------------------------------------
// urf_fifo: receive ring buffer
// Ring of DEPTH entries holding DEPTH-1 bytes, with a prefetched head byte,
// sticky overflow flag and flush.
// ----------------------------------------------------------------------------
module urf_fifo #(
  parameter int DEPTH = urf_pkg::FIFO_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                tick,
  input  logic                pop,
  input  logic                flush,
  input  logic                clr_ovf,
  input  urf_pkg::rx_evt_t    evt,
  output urf_pkg::fifo_stat_t stat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
  localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W + 1)'(DEPTH);

  logic [7:0]       mem [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic             ovf_r, ovf_nxt;
  logic [7:0]       rd_data_r;
  logic [7:0]       byp_r;
  logic             byp_sel_r;

  logic [PTR_W-1:0] rd_pop;
  logic [PTR_W-1:0] wr_inc;
  logic             full;
  logic             do_write;
  logic             not_empty;
  logic [PTR_W:0]   diff;
  logic [PTR_W:0]   fill_raw;
  logic [PTR_W+6:0] fill_ext;
  logic [7:0]       head;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == LAST_IDX) ? '0 : p + PTR_W'(1);
  endfunction

  assign not_empty = (wr_r != rd_r);
  assign diff      = {1'b0, wr_r} - {1'b0, rd_r};
  assign fill_raw  = diff[PTR_W] ? diff + DEPTH_EXT : diff;
  assign fill_ext  = (PTR_W + 7)'(fill_raw);

  assign rd_pop   = (pop && not_empty) ? ptr_inc(rd_r) : rd_r;
  assign wr_inc   = ptr_inc(wr_r);
  assign full     = (wr_inc == rd_pop);
  assign do_write = tick && evt.done && !full;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    ovf_nxt = ovf_r;
    if (tick) begin
      rd_nxt = rd_pop;
      if (clr_ovf) begin
        ovf_nxt = 1'b0;
      end
      if (evt.done && full) begin
        ovf_nxt = 1'b1;
      end
      if (do_write) begin
        wr_nxt = wr_inc;
      end
      if (flush) begin
        wr_nxt = '0;
        rd_nxt = '0;
      end
    end
  end

  // The head is read ahead at the next read pointer; a byte written in the
  // same cycle to that entry is forwarded.
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[wr_r] <= evt.data;
    end
    rd_data_r <= mem[rd_nxt];
    byp_r     <= evt.data;
    byp_sel_r <= do_write && (wr_r == rd_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      ovf_r <= 1'b0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign head = byp_sel_r ? byp_r : rd_data_r;

  assign stat.head_valid = not_empty;
  assign stat.head_byte  = not_empty ? head : 8'd0;
  assign stat.fill       = (fill_ext > (PTR_W + 7)'(urf_pkg::FILL_MAX)) ? urf_pkg::FILL_MAX
                                                                       : fill_ext[5:0];
  assign stat.overflow   = ovf_r;

endmodule

@@ hdl/uart_receiver_with_fifo.sv @@
// ----------------------------------------------------------------------------
// uart_receiver_with_fifo: 8-bit UART receiver with receive FIFO
// Top level: configuration registers, receiver, FIFO and the result register.
// ----------------------------------------------------------------------------
// Every input beat is one oversampling tick of the receive line and carries
// the line level plus the pop, flush and clear-overflow strobes. Each beat
// produces exactly one result beat, and a new beat is taken in each unstalled
// cycle: the FIFO status and receiver update are a single pass of logic
// between the state registers and the result register, and the head byte
// comes from a FIFO memory that is read ahead at the next read pointer. The
// input is stalled only while the result register is full and its own beat
// is stalled. The head byte, fill count, head valid and overflow flag describe
// the FIFO as it stood before the tick; frame_done marks the tick at which a
// frame's stop-bit wait ended and its byte was stored (or dropped, setting
// the sticky overflow flag). The FIFO holds FIFO_DEPTH-1 bytes. The memory
// needs no clearing after reset, so the block is ready at once. The user must
// write configuration via the plain cfg port only while idle (unchecked).
module uart_receiver_with_fifo #(
  parameter int FIFO_DEPTH = urf_pkg::FIFO_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input channel: one tick per beat.
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_rx_line,
  input  logic                            in_pop_req,
  input  logic                            in_flush_all,
  input  logic                            in_clear_overflow,
  // Result channel.
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_head_valid,
  output logic [7:0]                      out_head_byte,
  output logic [urf_pkg::FILL_W-1:0]      out_fill_count,
  output logic                            out_overflow_seen,
  output logic                            out_frame_done,
  // Configuration write port.
  input  logic                            cfg_wr_en,
  input  logic [urf_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [urf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  urf_pkg::cfg_t       cfg_r;
  urf_pkg::rx_evt_t    evt;
  urf_pkg::fifo_stat_t stat;

  logic tick;
  logic out_valid_r;

  // The result register can take a new beat when it is empty or draining.
  assign in_stall = out_valid_r && out_stall;
  assign tick     = in_valid && !in_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bit_period  <= urf_pkg::BIT_PERIOD_RST;
      cfg_r.first_delay <= urf_pkg::DELAY_RST;
      cfg_r.parity_en   <= 1'b0;
      cfg_r.invert      <= 1'b0;
    end else if (cfg_wr_en) begin
      case (urf_pkg::cfg_reg_t'(cfg_addr))
        urf_pkg::REG_BIT_PERIOD:  cfg_r.bit_period  <= cfg_wdata[urf_pkg::BIT_PERIOD_W-1:0];
        urf_pkg::REG_FIRST_DELAY: cfg_r.first_delay <= cfg_wdata[urf_pkg::DELAY_W-1:0];
        urf_pkg::REG_PARITY:      cfg_r.parity_en   <= cfg_wdata[0];
        urf_pkg::REG_INVERT:      cfg_r.invert      <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  urf_rx u_rx (
    .clk   (clk),
    .rst_n (rst_n),
    .tick  (tick),
    .line  (in_rx_line),
    .cfg   (cfg_r),
    .evt   (evt)
  );

  urf_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .tick    (tick),
    .pop     (in_pop_req),
    .flush   (in_flush_all),
    .clr_ovf (in_clear_overflow),
    .evt     (evt),
    .stat    (stat)
  );

  // Result register: status from before the tick plus this tick's frame end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tick) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      out_head_valid    <= stat.head_valid;
      out_head_byte     <= stat.head_byte;
      out_fill_count    <= stat.fill;
      out_overflow_seen <= stat.overflow;
      out_frame_done    <= evt.done;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  // The input is held off only while a finished result is waiting.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with an empty result register");

  // The overflow flag can only be set by a frame that ended on an accepted tick.
  a_ovf_from_frame: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(stat.overflow) |-> $past(tick && evt.done))
    else $error("overflow flag set without a completed frame");

  // A reported head byte exists exactly when the reported fill is nonzero.
  a_head_matches_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_head_valid == (out_fill_count != '0)))
    else $error("head valid disagrees with fill count");

  // An empty FIFO reports a zero head byte.
  a_empty_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_head_valid) |-> (out_head_byte == 8'd0))
    else $error("nonzero head byte reported on empty FIFO");
`endif

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the UART receiver with receive FIFO
// Feeds receive-line ticks made of serial frames, noise and FIFO strobes.
// A cycle-true predictor of the receiver and FIFO runs in lockstep and every
// result beat is compared field by field, under several register settings
// and several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DEPTH       = urf_pkg::FIFO_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int HOLD_CYCLES = 400;

  // Strobes forced onto the last tick of a frame: {pop, flush, clear}.
  localparam logic [2:0] END_NONE  = 3'b000;
  localparam logic [2:0] END_POP   = 3'b100;
  localparam logic [2:0] END_FLUSH = 3'b010;
  localparam logic [2:0] END_CLR   = 3'b001;

  // One input beat: one tick of the receive line plus the FIFO strobes.
  typedef struct packed {
    logic line;
    logic pop;
    logic flush;
    logic clr;
  } rx_tick_t;

  // One result beat as the block should report it.
  typedef struct packed {
    logic                       head_valid;
    logic [7:0]                 head_byte;
    logic [urf_pkg::FILL_W-1:0] fill;
    logic                       overflow;
    logic                       frame_done;
  } rx_status_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           in_rx_line = 1'b1;
  logic                           in_pop_req = 1'b0;
  logic                           in_flush_all = 1'b0;
  logic                           in_clear_overflow = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           out_head_valid;
  logic [7:0]                     out_head_byte;
  logic [urf_pkg::FILL_W-1:0]     out_fill_count;
  logic                           out_overflow_seen;
  logic                           out_frame_done;
  logic                           cfg_wr_en = 1'b0;
  logic [urf_pkg::CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [urf_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  uart_receiver_with_fifo dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_line        (in_rx_line),
    .in_pop_req        (in_pop_req),
    .in_flush_all      (in_flush_all),
    .in_clear_overflow (in_clear_overflow),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_head_valid    (out_head_valid),
    .out_head_byte     (out_head_byte),
    .out_fill_count    (out_fill_count),
    .out_overflow_seen (out_overflow_seen),
    .out_frame_done    (out_frame_done),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata)
  );

  // Ticks waiting to be driven and the status beats they must produce.
  rx_tick_t   tick_q[$];
  rx_status_t status_q[$];

  // Knobs set by the stimulus process and read by the driving processes.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned pop_pct = 0;
  int unsigned flush_permille = 0;
  int unsigned clr_pct = 0;
  int unsigned glitch_pct = 0;
  int unsigned hold_requests = 0;

  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  logic        tick_taken = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned ticks_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned settings_count = 0;

  // Predictor copy of the registers, the receiver and the FIFO.
  logic [urf_pkg::BIT_PERIOD_W-1:0] m_bit_period = urf_pkg::BIT_PERIOD_RST;
  logic [urf_pkg::DELAY_W-1:0]      m_first_delay = urf_pkg::DELAY_RST;
  logic                             exp_par = 1'b0;
  logic                             exp_inv = 1'b0;
  logic                             m_busy = 1'b0;
  logic [urf_pkg::DELAY_W-1:0]      m_count = '0;
  logic [urf_pkg::SLOT_W-1:0]       m_slot = '0;
  logic [7:0]                       m_shift = '0;
  logic                             m_last_line = 1'b1;
  logic [7:0]                       m_fifo [DEPTH];
  int unsigned                      m_wr = 0;
  int unsigned                      m_rd = 0;
  logic                             exp_ovf = 1'b0;
  int unsigned                      m_frames = 0;
  int unsigned                      m_drops = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  // A zero timing register behaves as one tick.
  function automatic int unsigned eff_period();
    return (m_bit_period == 0) ? 1 : m_bit_period;
  endfunction

  function automatic int unsigned eff_delay();
    return (m_first_delay == 0) ? 1 : m_first_delay;
  endfunction

  // Advances the predicted block by one tick and returns the status it reports.
  // Status is taken first, then pop, clear, receiver advance and flush, in
  // that order, so a flush on the tick a byte lands leaves the FIFO empty.
  function automatic rx_status_t predict_tick(rx_tick_t t);
    rx_status_t                 r;
    int unsigned                fill;
    int unsigned                nxt;
    logic [urf_pkg::FILL_W-1:0] fill_cut;
    logic                       start_seen;
    logic [urf_pkg::SLOT_W-1:0] stop_slot;
    logic [7:0]                 rx_data;
    fill = (m_wr + DEPTH - m_rd) % DEPTH;
    fill_cut = urf_pkg::FILL_W'(fill);
    r.head_valid = (fill != 0);
    r.head_byte = (fill != 0) ? m_fifo[m_rd] : 8'h00;
    r.fill = (fill > urf_pkg::FILL_MAX) ? urf_pkg::FILL_MAX : fill_cut;
    r.overflow = exp_ovf;
    r.frame_done = 1'b0;
    if (t.pop && fill != 0) m_rd = (m_rd + 1) % DEPTH;
    if (t.clr) exp_ovf = 1'b0;
    if (!m_busy) begin
      start_seen = exp_inv ? (!m_last_line && t.line) : (m_last_line && !t.line);
      if (start_seen) begin
        m_busy = 1'b1;
        m_slot = '0;
        m_shift = '0;
        m_count = urf_pkg::DELAY_W'(eff_delay());
      end
    end else begin
      m_count = m_count - urf_pkg::DELAY_W'(1);
      if (m_count == 0) begin
        stop_slot = exp_par ? 4'd9 : 4'd8;
        if (m_slot < urf_pkg::DATA_BITS) begin
          m_shift = {t.line, m_shift[7:1]};
          m_slot = m_slot + urf_pkg::SLOT_W'(1);
          m_count = urf_pkg::DELAY_W'(eff_period());
        end else if (m_slot < stop_slot) begin
          // Parity slot: sampled by the line but never checked.
          m_slot = m_slot + urf_pkg::SLOT_W'(1);
          m_count = urf_pkg::DELAY_W'(eff_period());
        end else begin
          rx_data = exp_inv ? ~m_shift : m_shift;
          nxt = (m_wr + 1) % DEPTH;
          if (nxt != m_rd) begin
            m_fifo[m_wr] = rx_data;
            m_wr = nxt;
          end else begin
            exp_ovf = 1'b1;
            m_drops++;
          end
          m_busy = 1'b0;
          m_slot = '0;
          r.frame_done = 1'b1;
          m_frames++;
        end
      end
    end
    m_last_line = t.line;
    if (t.flush) begin
      m_wr = 0;
      m_rd = 0;
    end
    return r;
  endfunction

  task automatic report_error(string msg);
    error_count++;
    $display("ERROR at result %0d: %s", results_seen, msg);
  endtask

  // Builds one tick at the given line level with strobes drawn from the knobs.
  function automatic rx_tick_t mk_tick(logic line);
    rx_tick_t t;
    t.line = line;
    t.pop = ($urandom_range(0, 99) < pop_pct);
    t.flush = ($urandom_range(0, 999) < flush_permille);
    t.clr = ($urandom_range(0, 99) < clr_pct);
    return t;
  endfunction

  // Queues one serial frame that carries the given byte under the current
  // registers. The line is held at idle level for one tick first so that the
  // start edge is real. Between sampling points the line may glitch, which
  // the receiver must ignore. With stop_at_start the line stays at the start
  // level after the frame, which must not start another frame.
  task automatic push_frame(logic [7:0] data, logic stop_at_start, logic [2:0] end_strobes);
    int unsigned fd;
    int unsigned bp;
    int unsigned last;
    int unsigned k;
    logic        idle_lvl;
    logic        lvl;
    logic        sample_tick;
    rx_tick_t    tk;
    fd = eff_delay();
    bp = eff_period();
    last = fd + (exp_par ? 9 : 8) * bp;
    idle_lvl = !exp_inv;
    tick_q.push_back(mk_tick(idle_lvl));
    for (int unsigned t = 0; t <= last; t++) begin
      sample_tick = (t >= fd) && ((t - fd) % bp == 0);
      if (t < fd) begin
        lvl = !idle_lvl;
      end else begin
        k = (t - fd) / bp;
        if (k < 8) lvl = data[k] ^ exp_inv;
        else if (k == 8 && exp_par) lvl = 1'($urandom_range(0, 1));
        else lvl = stop_at_start ? !idle_lvl : idle_lvl;
      end
      if (t != 0 && !sample_tick && $urandom_range(0, 99) < glitch_pct) lvl = !lvl;
      tk = mk_tick(lvl);
      if (t == last && end_strobes != END_NONE) {tk.pop, tk.flush, tk.clr} = end_strobes;
      tick_q.push_back(tk);
    end
    if (stop_at_start) repeat (3) tick_q.push_back(mk_tick(!idle_lvl));
  endtask

  task automatic push_noise();
    repeat ($urandom_range(1, 12)) tick_q.push_back(mk_tick(1'($urandom_range(0, 1))));
  endtask

  // Blocks until every queued tick was accepted and every result checked.
  task automatic wait_drained();
    do @(posedge clk); while (tick_q.size() != 0 || in_valid || status_q.size() != 0);
  endtask

  // Runs idle-level ticks until the predicted receiver is between frames, so
  // that no register changes under a frame in flight.
  task automatic settle_receiver();
    int unsigned left;
    wait_drained();
    while (m_busy) begin
      left = m_count + ((exp_par ? 9 : 8) - m_slot) * eff_period() + 1;
      repeat (left) tick_q.push_back(mk_tick(!exp_inv));
      wait_drained();
    end
  endtask

  task automatic write_reg(urf_pkg::cfg_reg_t idx, int unsigned value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= urf_pkg::CFG_DATA_W'(value);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      urf_pkg::REG_BIT_PERIOD:  m_bit_period = urf_pkg::BIT_PERIOD_W'(value);
      urf_pkg::REG_FIRST_DELAY: m_first_delay = urf_pkg::DELAY_W'(value);
      urf_pkg::REG_PARITY:      exp_par = value[0];
      urf_pkg::REG_INVERT:      exp_inv = value[0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(int unsigned bp, int unsigned fd, logic par, logic inv);
    settle_receiver();
    write_reg(urf_pkg::REG_BIT_PERIOD, bp);
    write_reg(urf_pkg::REG_FIRST_DELAY, fd);
    write_reg(urf_pkg::REG_PARITY, par);
    write_reg(urf_pkg::REG_INVERT, inv);
    settings_count++;
  endtask

  task automatic set_strobes(int unsigned pop_p, int unsigned flush_pm, int unsigned clr_p,
                             int unsigned glitch_p);
    pop_pct = pop_p;
    flush_permille = flush_pm;
    clr_pct = clr_p;
    glitch_pct = glitch_p;
  endtask

  // Input driver. A new beat is presented on the falling edge once the
  // previous one was taken; a stalled beat stays exactly as it was.
  always @(negedge clk) begin : drive_ticks
    rx_tick_t cur;
    if (rst_n && (!in_valid || tick_taken)) begin
      if (tick_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cur = tick_q.pop_front();
        in_valid <= 1'b1;
        in_rx_line <= cur.line;
        in_pop_req <= cur.pop;
        in_flush_all <= cur.flush;
        in_clear_overflow <= cur.clr;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result stall. A requested long hold-off is counted here; otherwise the
  // stall follows the current idling percentage.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_served + 1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Monitor: checks result beats against the oldest prediction, then runs
  // the predictor for an input beat taken on this same edge.
  always @(posedge clk) begin : watch_results
    rx_status_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (status_q.size() == 0) begin
          report_error("result beat arrived with nothing expected");
        end else begin
          want = status_q.pop_front();
          if (out_head_valid !== want.head_valid)
            report_error($sformatf("head_valid %b, expected %b", out_head_valid,
                                   want.head_valid));
          if (out_head_byte !== want.head_byte)
            report_error($sformatf("head_byte %h, expected %h", out_head_byte,
                                   want.head_byte));
          if (out_fill_count !== want.fill)
            report_error($sformatf("fill_count %0d, expected %0d", out_fill_count,
                                   want.fill));
          if (out_overflow_seen !== want.overflow)
            report_error($sformatf("overflow_seen %b, expected %b", out_overflow_seen,
                                   want.overflow));
          if (out_frame_done !== want.frame_done)
            report_error($sformatf("frame_done %b, expected %b", out_frame_done,
                                   want.frame_done));
        end
      end
      tick_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        status_q.push_back(predict_tick({in_rx_line, in_pop_req, in_flush_all,
                                         in_clear_overflow}));
        ticks_accepted++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               status_q.size());
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // A few idle ticks under the reset registers: no frame may start.
    repeat (2) tick_q.push_back(mk_tick(1'b1));

    // Directed part at the fastest timing.
    apply_setting(1, 1, 1'b0, 1'b0);
    // A pop on an empty FIFO does nothing.
    tick_q.push_back('{line: 1'b1, pop: 1'b1, flush: 1'b0, clr: 1'b0});
    push_frame(8'h00, 1'b0, END_NONE);
    push_frame(8'hFF, 1'b0, END_NONE);
    push_frame(8'h80, 1'b0, END_NONE);
    push_frame(8'h01, 1'b0, END_NONE);
    repeat (5) tick_q.push_back('{line: 1'b1, pop: 1'b1, flush: 1'b0, clr: 1'b0});
    // A byte landing on the tick of a flush is lost with the rest.
    push_frame(8'h3C, 1'b0, END_NONE);
    push_frame(8'hC3, 1'b0, END_FLUSH);
    // The line stays at the start level after the frame: no second frame.
    push_frame(8'hA5, 1'b0, END_NONE);
    push_frame(8'hA5, 1'b1, END_NONE);
    // Edges between the sampling points are ignored.
    glitch_pct = 50;
    push_frame(8'h5A, 1'b0, END_NONE);
    glitch_pct = 0;
    // Clearing an overflow flag that is not set, then a pop on a store tick.
    tick_q.push_back('{line: 1'b1, pop: 1'b0, flush: 1'b0, clr: 1'b1});
    push_frame(8'h96, 1'b0, END_POP);

    // Zero timing registers act as one, with parity and an inverted line.
    // The line starts out at the inverted start level, which is no edge.
    apply_setting(0, 0, 1'b1, 1'b1);
    repeat (3) tick_q.push_back(mk_tick(1'b1));
    push_frame(8'hC3, 1'b0, END_NONE);
    push_frame(8'h00, 1'b1, END_NONE);
    push_frame(8'hFF, 1'b0, END_POP);
    repeat (4) tick_q.push_back('{line: 1'b0, pop: 1'b1, flush: 1'b0, clr: 1'b0});
    // The sender waits here until every result so far has come.
    wait_drained();

    // Widest register values take effect; the line shows no start edge.
    apply_setting(131071, 262143, 1'b1, 1'b1);
    set_strobes(10, 0, 10, 0);
    repeat (20) tick_q.push_back(mk_tick(1'b0));

    // Random part: mostly well-formed frames with random content and timing,
    // some noise, under each idling pattern with its own register setting.
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 73; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 73; end
        default: begin send_idle_pct = 30; stall_pct = 30; end
      endcase
      apply_setting(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 2),
                    $urandom_range(0, 3), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
      set_strobes($urandom_range(2, 40), $urandom_range(0, 8), $urandom_range(0, 8),
                  $urandom_range(0, 15));
      // With no idling, hold the result side off while ticks keep coming
      // so the block fills up and stalls its input.
      if (mode == 0) hold_requests++;
      for (int u = 0; u < 6; u++) begin
        if ($urandom_range(0, 99) < 85)
          push_frame(8'($urandom_range(0, 255)), ($urandom_range(0, 9) == 0), END_NONE);
        else
          push_noise();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (status_q.size() != 0) report_error("expected results left over at the end");
    $display("Checked %0d ticks over %0d register settings and four idling patterns.",
             ticks_accepted, settings_count);
    $display("Frames received: %0d, bytes dropped on a full FIFO: %0d, mismatches: %0d.",
             m_frames, m_drops, error_count);
    if (error_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
